/* design/sm4_pkg.sv */
// SM4 block cipher unit: shared types, constants and lookup functions.
// Used by every module of the block; depends on nothing.
package sm4_pkg;

  localparam int ROUNDS    = 32;
  localparam int RND_W     = $clog2(ROUNDS);
  localparam int WORD_W    = 32;
  localparam int HALF_W    = 64;
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 64;

  localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUNDS - 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [RND_W-1:0]  rnd_t;

  // register indexes (byte address 8*index)
  typedef enum logic [1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1,
    REG_DECRYPT  = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_KEXP = 2'd1,
    ST_RUN  = 2'd2
  } state_t;

  typedef struct packed {
    logic [HALF_W-1:0] key_high;
    logic [HALF_W-1:0] key_low;
    logic              decrypt;
    logic              key_wr;
  } cfg_t;

  localparam word_t FK0 = 32'hA3B1BAC6;
  localparam word_t FK1 = 32'h56AA3350;
  localparam word_t FK2 = 32'h677D9197;
  localparam word_t FK3 = 32'hB27022DC;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // byte-wise S-box substitution
  function automatic word_t tau(input word_t x);
    word_t r;
    for (int b = 0; b < 4; b++) begin
      r[8*b +: 8] = SBOX[x[8*b +: 8]];
    end
    return r;
  endfunction

  // CK word: byte j from the top is (4*i + j) * 7 mod 256
  function automatic word_t ck_word(input rnd_t i);
    word_t w;
    logic [7:0] n;
    for (int j = 0; j < 4; j++) begin
      n = 8'({i, 2'(j)});
      w[8*(3-j) +: 8] = n * 8'd7;
    end
    return w;
  endfunction

endpackage

/* design/sm4_in_if.sv */
// Input block channel: valid/ready handshake with the plaintext or ciphertext block.
// Depends on sm4_pkg for the field widths.
interface sm4_in_if;
  import sm4_pkg::*;

  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] block_high;
  logic [HALF_W-1:0] block_low;
  logic              last_block;

  modport source (output valid, block_high, block_low, last_block, input ready);
  modport sink   (input valid, block_high, block_low, last_block, output ready);
endinterface

/* design/sm4_out_if.sv */
// Result block channel: valid/ready handshake with the processed block.
// Depends on sm4_pkg for the field widths.
interface sm4_out_if;
  import sm4_pkg::*;

  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] result_high;
  logic [HALF_W-1:0] result_low;
  logic              last;

  modport source (output valid, result_high, result_low, last, input ready);
  modport sink   (input valid, result_high, result_low, last, output ready);
endinterface

/* design/sm4_block_cipher_unit.sv */
// SM4 ECB block cipher unit, top level.
// Depends on sm4_pkg, sm4_in_if, sm4_out_if, sm4_regs, sm4_rk_ram and sm4_round.
//
// Usage:
//   Write the 128-bit key (key_high at 0x00, key_low at 0x08) and the direction
//   (decrypt at 0x10) over APB while the unit is idle. A key write starts a
//   key expansion; blocks are not taken until it is done.
//   Feed 128-bit blocks on in_ch; each result beat on out_ch carries the
//   processed block with its words reversed and a copy of last_block.
// Timing:
//   One round per cycle through a single shared round unit, except that the last
//   round of a block holds while the output register is full; the round key is
//   read from a 32-entry RAM in the cycle before its round. A new block is taken
//   only once the last one has left the round unit. Key expansion runs after a
//   key write and after reset: the key words are loaded, then the key rounds run.
// Reset and stalls:
//   rst (synchronous) drops all pending work and marks the round keys stale, so
//   the reset key (zero) is expanded first. If the receiver stalls, the result
//   waits in the output register; the next block is still accepted and runs up
//   to its last round, where it holds until the output register frees up.
module sm4_block_cipher_unit (
  input  logic                       clk,
  input  logic                       rst,
  sm4_in_if.sink                     in_ch,
  sm4_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sm4_pkg::APB_AW-1:0] paddr,
  input  logic [sm4_pkg::APB_DW-1:0] pwdata,
  output logic [sm4_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import sm4_pkg::*;

  cfg_t   cfg;
  state_t state;
  state_t state_next;
  rnd_t   count;
  rnd_t   count_next;
  logic   keys_ready;
  logic   keys_ready_next;
  word_t  words [4];
  logic   last_hold;

  logic   load_key;
  logic   load_blk;
  logic   step;
  logic   finish;
  logic   rk_we;
  logic   rd_en;
  rnd_t   raddr;
  word_t  rk_rdata;
  word_t  rnd_in;
  word_t  nx;
  logic   key_mode;
  logic   in_beat;
  logic   out_free;

  sm4_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sm4_rk_ram u_rk_ram (
    .clk   (clk),
    .we    (rk_we),
    .waddr (count),
    .wdata (nx),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rk_rdata)
  );

  assign key_mode = (state == ST_KEXP);
  assign rnd_in   = key_mode ? ck_word(count) : rk_rdata;

  sm4_round u_round (
    .w0       (words[0]),
    .w1       (words[1]),
    .w2       (words[2]),
    .w3       (words[3]),
    .rk       (rnd_in),
    .key_mode (key_mode),
    .nx       (nx)
  );

  assign in_ch.ready = (state == ST_IDLE) && keys_ready;
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      keys_ready <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      keys_ready <= keys_ready_next;
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    keys_ready_next = keys_ready;
    load_key        = 1'b0;
    load_blk        = 1'b0;
    step            = 1'b0;
    finish          = 1'b0;
    rk_we           = 1'b0;
    rd_en           = 1'b0;
    raddr           = cfg.decrypt ? ~count : count;
    case (state)
      ST_IDLE: begin
        count_next = '0;
        if (!keys_ready) begin
          load_key   = 1'b1;
          state_next = ST_KEXP;
        end else if (in_beat) begin
          // fetch the first round key alongside the block load
          load_blk   = 1'b1;
          rd_en      = 1'b1;
          raddr      = cfg.decrypt ? LAST_ROUND : '0;
          state_next = ST_RUN;
        end
      end
      ST_KEXP: begin
        step  = 1'b1;
        rk_we = 1'b1;
        count_next = count + 1'b1;
        if (count == LAST_ROUND) begin
          keys_ready_next = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_RUN: begin
        if (count != LAST_ROUND) begin
          step       = 1'b1;
          rd_en      = 1'b1;
          raddr      = cfg.decrypt ? ~(count + 1'b1) : count + 1'b1;
          count_next = count + 1'b1;
        end else if (out_free) begin
          step       = 1'b1;
          finish     = 1'b1;
          count_next = '0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // a new key restarts expansion unless a block is running
    if (cfg.key_wr && state != ST_RUN) begin
      keys_ready_next = 1'b0;
      state_next      = ST_IDLE;
      count_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_key) begin
      words[0] <= cfg.key_high[63:32] ^ FK0;
      words[1] <= cfg.key_high[31:0]  ^ FK1;
      words[2] <= cfg.key_low[63:32]  ^ FK2;
      words[3] <= cfg.key_low[31:0]   ^ FK3;
    end else if (load_blk) begin
      words[0] <= in_ch.block_high[63:32];
      words[1] <= in_ch.block_high[31:0];
      words[2] <= in_ch.block_low[63:32];
      words[3] <= in_ch.block_low[31:0];
    end else if (step) begin
      words[0] <= words[1];
      words[1] <= words[2];
      words[2] <= words[3];
      words[3] <= nx;
    end
  end

  always_ff @(posedge clk) begin
    if (load_blk) begin
      last_hold <= in_ch.last_block;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (finish) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  // output words come out reversed
  always_ff @(posedge clk) begin
    if (finish) begin
      out_ch.result_high <= {nx, words[3]};
      out_ch.result_low  <= {words[2], words[1]};
      out_ch.last        <= last_hold;
    end
  end

`ifndef SYNTHESIS
  a_ready_needs_keys: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> keys_ready)
    else $error("block accepted with stale round keys");

  a_accept_starts_run: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (state == ST_RUN && count == '0))
    else $error("accepted block did not start at round zero");

  a_stall_holds_last_round: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && count == LAST_ROUND && out_ch.valid && !out_ch.ready)
    |=> (state == ST_RUN && count == LAST_ROUND))
    else $error("last round advanced over a pending result");

  a_expansion_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KEXP && count == LAST_ROUND && !cfg.key_wr) |=> keys_ready)
    else $error("key expansion finished without marking keys ready");
`endif

endmodule

/* design/sm4_regs.sv */
// APB configuration registers: cipher key and direction select.
// Depends on sm4_pkg for cfg_t and the register indexes.
module sm4_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sm4_pkg::APB_AW-1:0] paddr,
  input  logic [sm4_pkg::APB_DW-1:0] pwdata,
  output logic [sm4_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output sm4_pkg::cfg_t              cfg
);
  import sm4_pkg::*;

  logic [HALF_W-1:0] key_high;
  logic [HALF_W-1:0] key_low;
  logic              decrypt;
  reg_idx_t          idx;
  logic              wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[APB_AW-1:3]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      decrypt  <= 1'b0;
    end else if (wr) begin
      case (idx)
        REG_KEY_HIGH: key_high <= pwdata;
        REG_KEY_LOW:  key_low  <= pwdata;
        REG_DECRYPT:  decrypt  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KEY_HIGH: prdata = key_high;
      REG_KEY_LOW:  prdata = key_low;
      REG_DECRYPT:  prdata = {{(APB_DW-1){1'b0}}, decrypt};
      default:      prdata = '0;
    endcase
  end

  assign cfg.key_high = key_high;
  assign cfg.key_low  = key_low;
  assign cfg.decrypt  = decrypt;
  assign cfg.key_wr   = wr && (idx inside {REG_KEY_HIGH, REG_KEY_LOW});

endmodule

/* design/sm4_rk_ram.sv */
// Round key store: one write port, one registered read port.
// Depends on sm4_pkg for the depth and word type.
module sm4_rk_ram (
  input  logic          clk,
  input  logic          we,
  input  sm4_pkg::rnd_t waddr,
  input  sm4_pkg::word_t wdata,
  input  logic          re,
  input  sm4_pkg::rnd_t raddr,
  output sm4_pkg::word_t rdata
);
  import sm4_pkg::*;

  word_t mem [ROUNDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold the read word while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/sm4_round.sv */
// Shared round function: S-box layer followed by the data or key linear map.
// Depends on sm4_pkg for tau and the word type.
module sm4_round (
  input  sm4_pkg::word_t w0,
  input  sm4_pkg::word_t w1,
  input  sm4_pkg::word_t w2,
  input  sm4_pkg::word_t w3,
  input  sm4_pkg::word_t rk,
  input  logic           key_mode,
  output sm4_pkg::word_t nx
);
  import sm4_pkg::*;

  word_t t;
  word_t lin;

  assign t = tau(w1 ^ w2 ^ w3 ^ rk);

  always_comb begin
    if (key_mode) begin
      lin = t ^ {t[18:0], t[31:19]} ^ {t[8:0], t[31:9]};
    end else begin
      lin = t ^ {t[29:0], t[31:30]} ^ {t[21:0], t[31:22]}
              ^ {t[13:0], t[31:14]} ^ {t[7:0], t[31:8]};
    end
  end

  assign nx = w0 ^ lin;

endmodule
